>>> rtl/core/kvt_pkg.sv
// shared types, constants and codes for the key-value table
`timescale 1ns / 1ps
`default_nettype none
package kvt_pkg;

    localparam int DEPTH = 16;
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int IDX_W = 4;
    localparam int CNT_W = 5;
    localparam int TYPE_W = 3;
    localparam int STAT_W = 3;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(DEPTH);

    // request codes
    localparam logic [TYPE_W-1:0] REQ_INSERT   = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_UPDATE   = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_UPSERT   = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_ERASE    = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_LOOKUP   = 3'd4;
    localparam logic [TYPE_W-1:0] REQ_CONTAINS = 3'd5;
    localparam logic [TYPE_W-1:0] REQ_SELECT   = 3'd6;

    // status codes
    localparam logic [STAT_W-1:0] ST_DONE    = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STAT_W-1:0] ST_PRESENT = 3'd2;
    localparam logic [STAT_W-1:0] ST_MISSING = 3'd3;
    localparam logic [STAT_W-1:0] ST_RANK    = 3'd4;

    typedef struct packed {
        logic load;
        logic strm_clr;
        logic strm_run;
        logic find;
        logic exec;
        logic sh_rd;
        logic sh_wr;
        logic sh_end;
        logic rk_ld;
        logic rk_cap;
        logic rk_chk;
        logic push;
    } t_cmd;

    typedef struct packed {
        logic strm_done;
        logic go_shift;
        logic go_rank;
        logic sh_more;
        logic rk_hit;
        logic rk_last;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

>>> rtl/core/kvt_ctrl.sv
// sequencer for the key-value table: one item at a time through scan, update, shift and rank steps
`timescale 1ns / 1ps
`default_nettype none
module kvt_ctrl
    import kvt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd,
    output logic      o_in_stall
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_FIND   = 10'b00_0000_0010,
        S_EXEC   = 10'b00_0000_0100,
        S_SH_RD  = 10'b00_0000_1000,
        S_SH_WR  = 10'b00_0001_0000,
        S_RK_LD  = 10'b00_0010_0000,
        S_RK_CAP = 10'b00_0100_0000,
        S_RK_CNT = 10'b00_1000_0000,
        S_RK_CHK = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.strm_clr = 1'b1;
                    n_state        = S_FIND;
                end
            end
            S_FIND: begin
                o_cmd.strm_run = 1'b1;
                o_cmd.find     = 1'b1;
                if (i_sts.strm_done) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_sts.go_shift) begin
                    n_state = S_SH_RD;
                end else if (i_sts.go_rank) begin
                    n_state = S_RK_LD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SH_RD: begin
                if (i_sts.sh_more) begin
                    o_cmd.sh_rd = 1'b1;
                    n_state     = S_SH_WR;
                end else begin
                    o_cmd.sh_end = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_SH_WR: begin
                o_cmd.sh_wr = 1'b1;
                n_state     = S_SH_RD;
            end
            S_RK_LD: begin
                o_cmd.rk_ld = 1'b1;
                n_state     = S_RK_CAP;
            end
            S_RK_CAP: begin
                o_cmd.rk_cap = 1'b1;
                n_state      = S_RK_CNT;
            end
            S_RK_CNT: begin
                o_cmd.strm_run = 1'b1;
                if (i_sts.strm_done) begin
                    n_state = S_RK_CHK;
                end
            end
            S_RK_CHK: begin
                o_cmd.rk_chk = 1'b1;
                if (i_sts.rk_hit || i_sts.rk_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RK_LD;
                end
            end
            S_DONE: begin
                // hold the result until the output register can take it
                if (i_sts.out_free) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

>>> rtl/core/kvt_dp.sv
// datapath of the key-value table: entry memories, scan pointer, counters and result registers
`timescale 1ns / 1ps
`default_nettype none
module kvt_dp
    import kvt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    input  wire logic              i_cfg_we,
    input  wire logic [CNT_W-1:0]  i_cfg_wdata,
    input  wire logic [TYPE_W-1:0] i_req_type,
    input  wire logic [KEY_W-1:0]  i_req_key,
    input  wire logic [VAL_W-1:0]  i_req_value,
    input  wire logic [CNT_W-1:0]  i_req_rank,
    input  wire logic              i_out_stall,
    output logic                   o_out_valid,
    output logic                   o_ok,
    output logic [STAT_W-1:0]      o_status,
    output logic [KEY_W-1:0]       o_found_key,
    output logic [VAL_W-1:0]       o_found_value,
    output logic [CNT_W-1:0]       o_entry_count,
    output logic                   o_is_empty
);

    logic [KEY_W-1:0] key_mem [DEPTH];
    logic [VAL_W-1:0] val_mem [DEPTH];

    logic [CNT_W-1:0]  r_cap;
    logic [CNT_W-1:0]  r_count;
    logic [TYPE_W-1:0] r_type;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_val;
    logic [CNT_W-1:0]  r_rank;
    logic [CNT_W-1:0]  r_ptr;
    logic              r_pend;
    logic [IDX_W-1:0]  r_pidx;
    logic              r_hit;
    logic [IDX_W-1:0]  r_slot;
    logic [VAL_W-1:0]  r_hit_val;
    logic [CNT_W-1:0]  r_j;
    logic [KEY_W-1:0]  r_cand_key;
    logic [VAL_W-1:0]  r_cand_val;
    logic [CNT_W-1:0]  r_smaller;
    logic [KEY_W-1:0]  r_kdata;
    logic [VAL_W-1:0]  r_vdata;
    logic              r_res_ok;
    logic [STAT_W-1:0] r_res_status;
    logic [KEY_W-1:0]  r_res_fkey;
    logic [VAL_W-1:0]  r_res_fval;
    logic              r_out_vld;
    logic              r_out_ok;
    logic [STAT_W-1:0] r_out_status;
    logic [KEY_W-1:0]  r_out_fkey;
    logic [VAL_W-1:0]  r_out_fval;
    logic [CNT_W-1:0]  r_out_cnt;
    logic              r_out_empty;

    logic [CNT_W-1:0]  eff_cap;
    logic              full;
    logic              issue;
    logic              ex_ok;
    logic [STAT_W-1:0] ex_status;
    logic [VAL_W-1:0]  ex_fval;
    logic              ex_ins;
    logic              ex_upd;
    logic              kwe;
    logic              vwe;
    logic [IDX_W-1:0]  waddr;
    logic [KEY_W-1:0]  wkey;
    logic [VAL_W-1:0]  wval;
    logic [IDX_W-1:0]  raddr;
    logic [CNT_W-1:0]  ptr_inc;

    assign eff_cap = (r_cap > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : r_cap;
    assign full    = (r_count >= eff_cap);
    assign issue   = (r_ptr < r_count);
    assign ptr_inc = r_ptr + CNT_W'(1);

    // outcome of a request once the key scan is over
    always_comb begin
        ex_ok     = 1'b0;
        ex_status = ST_DONE;
        ex_fval   = '0;
        ex_ins    = 1'b0;
        ex_upd    = 1'b0;
        case (r_type)
            REQ_INSERT, REQ_UPSERT: begin
                if (r_type == REQ_UPSERT && r_hit) begin
                    ex_upd = 1'b1;
                    ex_ok  = 1'b1;
                end else if (full) begin
                    ex_status = ST_FULL;
                end else if (r_hit) begin
                    ex_status = ST_PRESENT;
                end else begin
                    ex_ins = 1'b1;
                    ex_ok  = 1'b1;
                end
            end
            REQ_UPDATE: begin
                if (r_hit) begin
                    ex_upd = 1'b1;
                    ex_ok  = 1'b1;
                end else begin
                    ex_status = ST_MISSING;
                end
            end
            REQ_ERASE, REQ_CONTAINS: begin
                if (r_hit) begin
                    ex_ok = 1'b1;
                end else begin
                    ex_status = ST_MISSING;
                end
            end
            REQ_LOOKUP: begin
                if (r_hit) begin
                    ex_ok   = 1'b1;
                    ex_fval = r_hit_val;
                end else begin
                    ex_status = ST_MISSING;
                end
            end
            REQ_SELECT: begin
                // stays a rank failure unless the rank walk finds the entry
                ex_status = ST_RANK;
            end
            default: begin
                ex_ok = 1'b0;
            end
        endcase
    end

    assign kwe   = (i_cmd.exec && ex_ins) || i_cmd.sh_wr;
    assign vwe   = (i_cmd.exec && (ex_ins || ex_upd)) || i_cmd.sh_wr;
    assign waddr = i_cmd.sh_wr ? r_ptr[IDX_W-1:0]
                 : (ex_ins ? r_count[IDX_W-1:0] : r_slot);
    assign wkey  = i_cmd.sh_wr ? r_kdata : r_key;
    assign wval  = i_cmd.sh_wr ? r_vdata : r_val;
    assign raddr = i_cmd.sh_rd ? ptr_inc[IDX_W-1:0]
                 : (i_cmd.rk_ld ? r_j[IDX_W-1:0] : r_ptr[IDX_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (kwe) begin
            key_mem[waddr] <= wkey;
        end
        if (vwe) begin
            val_mem[waddr] <= wval;
        end
        r_kdata <= key_mem[raddr];
        r_vdata <= val_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= CAP_RESET;
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_hit     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end

            if (i_cmd.load) begin
                r_type <= i_req_type;
                r_key  <= i_req_key;
                r_val  <= i_req_value;
                r_rank <= i_req_rank;
                r_hit  <= 1'b0;
            end

            // read stream over slots 0 .. count-1, data arrives in the following cycle
            if (i_cmd.strm_clr || i_cmd.rk_cap) begin
                r_ptr  <= '0;
                r_pend <= 1'b0;
            end else if (i_cmd.strm_run) begin
                r_ptr  <= issue ? ptr_inc : r_ptr;
                r_pend <= issue;
                r_pidx <= r_ptr[IDX_W-1:0];
            end

            if (i_cmd.find && r_pend && !r_hit && r_kdata == r_key) begin
                r_hit     <= 1'b1;
                r_slot    <= r_pidx;
                r_hit_val <= r_vdata;
            end

            if (i_cmd.strm_run && !i_cmd.find && r_pend && r_kdata < r_cand_key) begin
                r_smaller <= r_smaller + CNT_W'(1);
            end

            if (i_cmd.exec) begin
                r_res_ok     <= ex_ok;
                r_res_status <= ex_status;
                r_res_fkey   <= '0;
                r_res_fval   <= ex_fval;
                r_ptr        <= CNT_W'(r_slot);
                r_j          <= '0;
                if (ex_ins) begin
                    r_count <= r_count + CNT_W'(1);
                end
            end

            if (i_cmd.sh_wr) begin
                r_ptr <= ptr_inc;
            end
            if (i_cmd.sh_end) begin
                r_count <= r_count - CNT_W'(1);
            end

            if (i_cmd.rk_cap) begin
                r_cand_key <= r_kdata;
                r_cand_val <= r_vdata;
                r_smaller  <= '0;
            end
            if (i_cmd.rk_chk) begin
                if (r_smaller == r_rank) begin
                    r_res_ok     <= 1'b1;
                    r_res_status <= ST_DONE;
                    r_res_fkey   <= r_cand_key;
                    r_res_fval   <= r_cand_val;
                end else begin
                    r_j <= r_j + CNT_W'(1);
                end
            end

            if (i_cmd.push) begin
                r_out_vld    <= 1'b1;
                r_out_ok     <= r_res_ok;
                r_out_status <= r_res_status;
                r_out_fkey   <= r_res_fkey;
                r_out_fval   <= r_res_fval;
                r_out_cnt    <= r_count;
                r_out_empty  <= (r_count == '0);
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_sts.strm_done = !issue && !r_pend;
    assign o_sts.go_shift  = (r_type == REQ_ERASE) && r_hit;
    assign o_sts.go_rank   = (r_type == REQ_SELECT) && (r_rank < r_count);
    assign o_sts.sh_more   = (ptr_inc < r_count);
    assign o_sts.rk_hit    = (r_smaller == r_rank);
    assign o_sts.rk_last   = ((r_j + CNT_W'(1)) >= r_count);
    assign o_sts.out_free  = !r_out_vld || !i_out_stall;

    assign o_out_valid   = r_out_vld;
    assign o_ok          = r_out_ok;
    assign o_status      = r_out_status;
    assign o_found_key   = r_out_fkey;
    assign o_found_value = r_out_fval;
    assign o_entry_count = r_out_cnt;
    assign o_is_empty    = r_out_empty;

endmodule
`default_nettype wire

>>> rtl/core/key_value_table_rank_select_unit.sv
// top level of the key-value table with rank select: sequencer, datapath and checks
//
//  channel   direction  handshake                  payload
//  request   in         i_in_valid / o_in_stall    i_req_type, i_req_key, i_req_value, i_req_rank
//  result    out        o_out_valid / i_out_stall  o_ok, o_status, o_found_key, o_found_value,
//                                                  o_entry_count, o_is_empty
//  config    in         i_cfg_we                   i_cfg_wdata (capacity limit)
//
// one item at a time; every item starts with a key scan of the stored entries
// through the single read port of the entry memories, then the outcome is registered and pushed to the output register
// erase moves each entry behind the erased one down a slot, a read and a write per entry; select tries
// each entry in turn as candidate and counts the keys below it, until the rank matches or none is left
// reset empties the table and sets the capacity limit to 16; the memories are not cleared
// a new item is taken while the previous result waits in the output register
`timescale 1ns / 1ps
`default_nettype none
module key_value_table_rank_select_unit
    import kvt_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CNT_W-1:0]  i_cfg_wdata,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [TYPE_W-1:0] i_req_type,
    input  wire logic [KEY_W-1:0]  i_req_key,
    input  wire logic [VAL_W-1:0]  i_req_value,
    input  wire logic [CNT_W-1:0]  i_req_rank,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_ok,
    output logic [STAT_W-1:0]      o_status,
    output logic [KEY_W-1:0]       o_found_key,
    output logic [VAL_W-1:0]       o_found_value,
    output logic [CNT_W-1:0]       o_entry_count,
    output logic                   o_is_empty
);

    t_cmd cmd;
    t_sts sts;

    kvt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    kvt_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_type    (i_req_type),
        .i_req_key     (i_req_key),
        .i_req_value   (i_req_value),
        .i_req_rank    (i_req_rank),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_ok          (o_ok),
        .o_status      (o_status),
        .o_found_key   (o_found_key),
        .o_found_value (o_found_value),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty)
    );

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |=> o_out_valid)
        else $error("result push did not show on the output");

    a_count_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_entry_count <= CNT_W'(DEPTH)))
        else $error("entry count above table depth");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_empty == (o_entry_count == '0)))
        else $error("empty flag disagrees with entry count");

    a_ok_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_ok) |-> (o_status == ST_DONE))
        else $error("successful result with a failure status");

endmodule
`default_nettype wire

>>> verif/tb_key_value_table_rank_select_unit.sv
// testbench for the key-value table: directed and random requests checked against a predictor
`timescale 1ns / 1ps
module tb_key_value_table_rank_select_unit;
    import kvt_pkg::*;

    localparam logic [TYPE_W-1:0] REQ_UNKNOWN = 3'd7;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int POOL_SIZE = 20;

    typedef struct {
        logic              ok;
        logic [STAT_W-1:0] status;
        logic [KEY_W-1:0]  found_key;
        logic [VAL_W-1:0]  found_value;
        logic [CNT_W-1:0]  entry_count;
        logic              is_empty;
    } table_reply_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CNT_W-1:0]  i_cfg_wdata = '0;
    logic              i_in_valid = 1'b0;
    logic [TYPE_W-1:0] i_req_type = '0;
    logic [KEY_W-1:0]  i_req_key = '0;
    logic [VAL_W-1:0]  i_req_value = '0;
    logic [CNT_W-1:0]  i_req_rank = '0;
    logic              i_out_stall = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic              o_ok;
    logic [STAT_W-1:0] o_status;
    logic [KEY_W-1:0]  o_found_key;
    logic [VAL_W-1:0]  o_found_value;
    logic [CNT_W-1:0]  o_entry_count;
    logic              o_is_empty;

    // predicted table contents
    logic [KEY_W-1:0] table_keys [DEPTH];
    logic [VAL_W-1:0] table_values [DEPTH];
    int               table_count = 0;
    int               table_capacity = DEPTH;

    table_reply_t     pending_replies [$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    int               mismatches = 0;
    int               cycle_count = 0;
    bit               tx_idle_on = 1'b1;
    bit               rx_idle_on = 1'b1;
    int               hold_requests = 0;
    int               hold_served = 0;
    int               hold_left = 0;

    key_value_table_rank_select_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_req_key     (i_req_key),
        .i_req_value   (i_req_value),
        .i_req_rank    (i_req_rank),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_ok          (o_ok),
        .o_status      (o_status),
        .o_found_key   (o_found_key),
        .o_found_value (o_found_value),
        .o_entry_count (o_entry_count),
        .o_is_empty    (o_is_empty)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result stall: random, off, or a long counted hold-off on request
    always @(negedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (rx_idle_on) begin
            i_out_stall <= ($urandom_range(99) < 15);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic table_reply_t apply_request(input logic [TYPE_W-1:0] kind,
                                                   input logic [KEY_W-1:0] key,
                                                   input logic [VAL_W-1:0] value,
                                                   input logic [CNT_W-1:0] rank);
        table_reply_t reply;
        int slot;
        int limit;
        int smaller;
        reply = '{ok: 1'b0, status: ST_DONE, found_key: '0, found_value: '0,
                  entry_count: '0, is_empty: 1'b0};
        slot = -1;
        for (int i = 0; i < table_count; i++) begin
            if (slot < 0 && table_keys[i] == key) slot = i;
        end
        limit = (table_capacity > DEPTH) ? DEPTH : table_capacity;
        case (kind)
            REQ_INSERT, REQ_UPSERT: begin
                if (kind == REQ_UPSERT && slot >= 0) begin
                    table_values[slot] = value;
                    reply.ok = 1'b1;
                end else if (table_count >= limit) begin
                    reply.status = ST_FULL;
                end else if (slot >= 0) begin
                    reply.status = ST_PRESENT;
                end else begin
                    table_keys[table_count] = key;
                    table_values[table_count] = value;
                    table_count++;
                    reply.ok = 1'b1;
                end
            end
            REQ_UPDATE: begin
                if (slot >= 0) begin
                    table_values[slot] = value;
                    reply.ok = 1'b1;
                end else begin
                    reply.status = ST_MISSING;
                end
            end
            REQ_ERASE: begin
                if (slot >= 0) begin
                    for (int j = slot; j + 1 < table_count; j++) begin
                        table_keys[j] = table_keys[j + 1];
                        table_values[j] = table_values[j + 1];
                    end
                    table_count--;
                    reply.ok = 1'b1;
                end else begin
                    reply.status = ST_MISSING;
                end
            end
            REQ_LOOKUP, REQ_CONTAINS: begin
                if (slot >= 0) begin
                    reply.ok = 1'b1;
                    if (kind == REQ_LOOKUP) reply.found_value = table_values[slot];
                end else begin
                    reply.status = ST_MISSING;
                end
            end
            REQ_SELECT: begin
                // keys are unique, so exactly one entry has each rank below the count
                for (int j = 0; j < table_count; j++) begin
                    smaller = 0;
                    for (int k = 0; k < table_count; k++) begin
                        if (table_keys[k] < table_keys[j]) smaller++;
                    end
                    if (!reply.ok && smaller == int'(rank)) begin
                        reply.found_key = table_keys[j];
                        reply.found_value = table_values[j];
                        reply.ok = 1'b1;
                    end
                end
                if (!reply.ok) reply.status = ST_RANK;
            end
            default: begin
            end
        endcase
        reply.entry_count = CNT_W'(table_count);
        reply.is_empty = (table_count == 0);
        return reply;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        table_reply_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_replies.size() == 0) begin
                $error("result item with nothing expected");
                mismatches++;
            end else begin
                want = pending_replies.pop_front();
                check_field("ok", 32'(want.ok), 32'(o_ok));
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("found_key", want.found_key, o_found_key);
                check_field("found_value", want.found_value, o_found_value);
                check_field("entry_count", 32'(want.entry_count), 32'(o_entry_count));
                check_field("is_empty", 32'(want.is_empty), 32'(o_is_empty));
            end
        end
    end

    // called and returns at a falling edge; valid stays high for a following item
    task automatic send_request(input logic [TYPE_W-1:0] kind, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] value, input logic [CNT_W-1:0] rank);
        int gap;
        if (tx_idle_on && $urandom_range(99) < 15) begin
            gap = $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= kind;
        i_req_key <= key;
        i_req_value <= value;
        i_req_rank <= rank;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_replies.push_back(apply_request(kind, key, value, rank));
        @(negedge i_clk);
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_capacity(input logic [CNT_W-1:0] limit);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= limit;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        table_capacity = int'(limit);
    endtask

    function automatic logic [KEY_W-1:0] pick_key;
        int roll;
        roll = $urandom_range(99);
        if (roll < 55 && table_count > 0) return table_keys[$urandom_range(0, table_count - 1)];
        if (roll < 85) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return $urandom;
    endfunction

    task automatic random_request;
        int roll;
        logic [TYPE_W-1:0] kind;
        logic [CNT_W-1:0] rank;
        roll = $urandom_range(99);
        if (roll < 25) kind = REQ_INSERT;
        else if (roll < 40) kind = REQ_UPSERT;
        else if (roll < 50) kind = REQ_UPDATE;
        else if (roll < 65) kind = REQ_ERASE;
        else if (roll < 77) kind = REQ_LOOKUP;
        else if (roll < 85) kind = REQ_CONTAINS;
        else if (roll < 98) kind = REQ_SELECT;
        else kind = REQ_UNKNOWN;
        if ($urandom_range(99) < 80) rank = CNT_W'($urandom_range(0, table_count));
        else rank = CNT_W'($urandom_range(0, 31));
        send_request(kind, pick_key(), $urandom, rank);
    endtask

    task automatic test_directed;
        send_request(REQ_LOOKUP, 32'h0, $urandom, 5'd0);
        send_request(REQ_SELECT, 32'h0, $urandom, 5'd0);
        send_request(REQ_ERASE, 32'h5, $urandom, 5'd0);
        send_request(REQ_UPDATE, 32'h5, 32'h1, 5'd0);
        send_request(REQ_CONTAINS, 32'h5, $urandom, 5'd0);
        send_request(REQ_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
        send_request(REQ_INSERT, 32'h0, 32'hFFFF_FFFF, 5'd0);
        send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'h0, 5'd31);
        send_request(REQ_INSERT, 32'h0, 32'h1234_5678, 5'd0);
        send_request(REQ_INSERT, 32'h8000_0000, 32'h1234_5678, 5'd0);
        send_request(REQ_UPSERT, 32'h0, 32'hA5A5_A5A5, 5'd0);
        send_request(REQ_UPSERT, 32'h7FFF_FFFF, 32'h5A5A_5A5A, 5'd0);
        send_request(REQ_LOOKUP, 32'hFFFF_FFFF, $urandom, 5'd0);
        send_request(REQ_CONTAINS, 32'h8000_0000, $urandom, 5'd0);
        send_request(REQ_SELECT, $urandom, $urandom, 5'd0);
        send_request(REQ_SELECT, $urandom, $urandom, 5'd3);
        send_request(REQ_SELECT, $urandom, $urandom, 5'd4);
        send_request(REQ_SELECT, $urandom, $urandom, 5'd31);
        send_request(REQ_UPDATE, 32'h8000_0000, 32'h0, 5'd0);
        // first entry erased, everything behind it moves down
        send_request(REQ_ERASE, 32'h0, $urandom, 5'd0);
        send_request(REQ_ERASE, 32'h8000_0000, $urandom, 5'd0);
        send_request(REQ_UNKNOWN, 32'h7FFF_FFFF, $urandom, 5'd0);
        send_request(REQ_ERASE, 32'h7FFF_FFFF, $urandom, 5'd0);
        send_request(REQ_ERASE, 32'hFFFF_FFFF, $urandom, 5'd0);
    endtask

    task automatic test_capacity_limits;
        write_capacity(5'd2);
        send_request(REQ_INSERT, 32'h11, 32'h1, 5'd0);
        send_request(REQ_INSERT, 32'h22, 32'h2, 5'd0);
        send_request(REQ_INSERT, 32'h33, 32'h3, 5'd0);
        // full wins over key already present
        send_request(REQ_INSERT, 32'h11, 32'h4, 5'd0);
        send_request(REQ_UPSERT, 32'h11, 32'h5, 5'd0);
        send_request(REQ_UPSERT, 32'h33, 32'h6, 5'd0);
        // limit below the stored count keeps every entry
        write_capacity(5'd0);
        send_request(REQ_LOOKUP, 32'h22, $urandom, 5'd0);
        send_request(REQ_INSERT, 32'h44, 32'h7, 5'd0);
        // limit above the depth acts as the depth
        write_capacity(5'd31);
        send_request(REQ_INSERT, 32'h33, 32'h8, 5'd0);
    endtask

    task automatic test_output_hold;
        hold_requests++;
        repeat (12) random_request();
        drain();
    endtask

    task automatic test_random;
        logic [CNT_W-1:0] phase_limits [6];
        phase_limits = '{5'd16, 5'd4, 5'd0, 5'd31, 5'd1, 5'd10};
        key_pool[0] = 32'h0;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
        for (int phase = 0; phase < 6; phase++) begin
            write_capacity(phase_limits[phase]);
            tx_idle_on = (phase != 3);
            rx_idle_on = (phase != 3);
            repeat (150) random_request();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_capacity_limits();
        for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
        test_output_hold();
        test_random();
        drain();
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
